[design/chlp_pkg.sv]
// package for the cpu hotplug load policy block
// constants, state type and action codes; no dependencies
package chlp_pkg;

  localparam int unsigned CpuCountDefault = 4;

  localparam logic [6:0] LoadIn = 7'd95;
  localparam logic [6:0] LoadOutPerCpu = 7'd3;
  localparam logic [6:0] LoadStep = 7'd10;
  localparam logic [16:0] TaskHigh = 17'd199;
  localparam logic [16:0] TaskLow = 17'd110;
  localparam logic [3:0] CpuSplit = 4'd2;
  localparam logic [7:0] RunInNeeded = 8'd3;
  localparam logic [7:0] RunOutNeeded = 8'd6;
  localparam logic [7:0] LoadInNeeded = 8'd3;
  localparam logic [7:0] LoadOutNeededMany = 8'd20;
  localparam logic [7:0] LoadOutNeededFew = 8'd200;
  localparam logic [6:0] LoadFull = 7'd100;

  localparam logic [1:0] RegBlocked = 2'd0;
  localparam logic [1:0] RegMaxOnline = 2'd1;
  localparam logic [1:0] RegMinOnline = 2'd2;

  typedef enum logic [1:0] {
    ActNone = 2'd0,
    ActUp   = 2'd1,
    ActDown = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StLoadDiv,
    StAvgDiv,
    StDecide,
    StOut
  } state_e;

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c == 8'hFF) ? c : c + 8'd1;
  endfunction

endpackage

[design/cpu_hotplug_load_policy.sv]
// top level of the cpu hotplug load policy block
// uses chlp_pkg for constants, codes and the state type
//
// One item is one cpu's cumulative idle, iowait and wall times. The block forms
// 32-bit deltas against the stored values of that cpu, then works out the cpu's
// load with a restoring divider that retires one quotient bit a cycle over the
// 39-bit numerator. On an item with last_cpu set, a second pass of the same
// divider gives running_tasks*100 over the online count, the hysteresis
// counters update and one result item leaves through the output register. A
// skipped cpu skips the load division. A result held by out_stall keeps the
// input stalled until it is taken. While hotplug_blocked is set and no result
// is held, items are taken and dropped, one a cycle. The block takes one item
// at a time.
module cpu_hotplug_load_policy #(
  parameter int unsigned CpuCount = chlp_pkg::CpuCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  cpu_index_i,
  input  logic [63:0] idle_total_i,
  input  logic [63:0] iowait_total_i,
  input  logic        iowait_valid_i,
  input  logic [63:0] wall_total_i,
  input  logic        last_cpu_i,
  input  logic [9:0]  running_tasks_i,
  input  logic [3:0]  online_cpus_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  action_o,
  output logic [3:0]  target_cpu_o,
  output logic [6:0]  peak_load_o,
  output logic [6:0]  floor_load_o,
  output logic [16:0] avg_running_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);
  import chlp_pkg::*;

  localparam int unsigned IdxW = (CpuCount > 1) ? $clog2(CpuCount) : 1;

  state_e state_q, state_d;

  // configuration
  logic       blocked_q;
  logic [3:0] max_on_q, min_on_q;

  // per cpu history
  logic [63:0] prev_idle_q [CpuCount];
  logic [63:0] prev_wall_q [CpuCount];

  // sample tracking
  logic [6:0] run_max_q, run_min_q;
  logic [7:0] trise_q, tfall_q, lrise_q, lfall_q;

  // latched last item fields
  logic       last_q;
  logic [9:0] tasks_q;
  logic [3:0] n_q;

  // shared restoring divider: quotient bits shift in one a cycle
  logic [38:0] dividend_q;  // numerator shifted out msb first
  logic [31:0] divisor_q;
  logic [32:0] rem_q;
  logic [38:0] quot_q;
  logic [5:0]  cnt_q;

  // output register
  logic        ov_q;
  logic [1:0]  act_q;
  logic [3:0]  tgt_q;
  logic [6:0]  omax_q, omin_q;
  logic [16:0] oavg_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_q != StIdle) || ov_q;
  assign out_valid = ov_q;
  assign action_o = act_q;
  assign target_cpu_o = tgt_q;
  assign peak_load_o = omax_q;
  assign floor_load_o = omin_q;
  assign avg_running_o = oavg_q;

  wire in_acc = in_valid && !in_stall;

  // per cpu delta and skip check on the accepted item
  logic [IdxW-1:0] idx;
  logic            idx_ok;
  logic [63:0]     idle_eff;
  logic [31:0]     didle, dwall;
  logic            skip;
  logic [3:0]      n_in;
  always_comb begin
    idx = cpu_index_i[IdxW-1:0];
    idx_ok = ({28'd0, cpu_index_i} < 32'(CpuCount));
    idle_eff = (iowait_valid_i && idle_total_i >= iowait_total_i) ?
               idle_total_i - iowait_total_i : idle_total_i;
    dwall = wall_total_i[31:0] - prev_wall_q[idx][31:0];
    didle = idle_eff[31:0] - prev_idle_q[idx][31:0];
    skip = !idx_ok || dwall == 32'd0 || dwall < didle;
    n_in = (online_cpus_i == 4'd0) ? 4'd1 : online_cpus_i;
  end

  // divider step
  logic [32:0] trial, rem_sh;
  always_comb begin
    rem_sh = {rem_q[31:0], dividend_q[38]};
    trial = rem_sh - {1'b0, divisor_q};
  end

  // decision logic from the counters updated with this sample
  logic [16:0] avg;
  logic [7:0]  tr, tf, lr, lf;
  logic        up, down;
  logic signed [7:0] thr;
  logic [7:0]  sum_ml;
  always_comb begin
    avg = quot_q[16:0];
    tr = trise_q; tf = tfall_q; lr = lrise_q; lf = lfall_q;
    if (avg > TaskHigh) begin
      tr = sat_inc(trise_q); tf = 8'd0;
    end else if (avg < TaskLow) begin
      tr = 8'd0; tf = sat_inc(tfall_q);
    end
    thr = $signed({1'b0, LoadIn}) - $signed(8'(n_q - 4'd1) * 8'(LoadStep));
    sum_ml = {1'b0, run_max_q} + {1'b0, run_min_q};
    if ($signed({1'b0, run_min_q}) > thr) begin
      lr = sat_inc(lrise_q); lf = 8'd0;
    end else if ((n_q > CpuSplit && (sum_ml < {1'b0, LoadIn} ||
                  {1'b0, run_min_q} < 8'(n_q) * 8'(LoadOutPerCpu))) ||
                 (n_q <= CpuSplit && sum_ml < {1'b0, LoadIn})) begin
      lf = sat_inc(lfall_q); lr = 8'd0;
    end
    up = tr >= RunInNeeded && lr >= LoadInNeeded && max_on_q > n_q;
    down = !up && tf >= RunOutNeeded && min_on_q < n_q &&
           ((n_q > CpuSplit && lf >= LoadOutNeededMany) ||
            (n_q <= CpuSplit && lf >= LoadOutNeededFew));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc && !blocked_q) begin
          if (!skip) state_d = StLoadDiv;
          else if (last_cpu_i) state_d = StAvgDiv;
        end
      end
      StLoadDiv: begin
        if (cnt_q == 6'd0) state_d = last_q ? StAvgDiv : StIdle;
      end
      StAvgDiv: begin
        if (cnt_q == 6'd0) state_d = StDecide;
      end
      StDecide: state_d = StOut;
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q <= 1'b0;
      max_on_q <= 4'd4;
      min_on_q <= 4'd1;
      for (int i = 0; i < int'(CpuCount); i++) begin
        prev_idle_q[i] <= 64'd0;
        prev_wall_q[i] <= 64'd0;
      end
      run_max_q <= 7'd0;
      run_min_q <= LoadFull;
      trise_q <= 8'd0;
      tfall_q <= 8'd0;
      lrise_q <= 8'd0;
      lfall_q <= 8'd0;
      ov_q <= 1'b0;
      last_q <= 1'b0;
      cnt_q <= 6'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index_i)
          RegBlocked: blocked_q <= cfg_data_i[0];
          RegMaxOnline: max_on_q <= cfg_data_i;
          RegMinOnline: min_on_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ov_q && !out_stall) ov_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_acc && !blocked_q) begin
            last_q <= last_cpu_i;
            if (idx_ok) begin
              prev_idle_q[idx] <= idle_eff;
              prev_wall_q[idx] <= wall_total_i;
            end
            cnt_q <= skip ? 6'd16 : 6'd39;
          end
        end
        StLoadDiv: begin
          if (cnt_q == 6'd0) begin
            if (quot_q[6:0] > run_max_q) run_max_q <= quot_q[6:0];
            if (quot_q[6:0] < run_min_q) run_min_q <= quot_q[6:0];
            cnt_q <= 6'd16;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        StAvgDiv: begin
          if (cnt_q != 6'd0) cnt_q <= cnt_q - 6'd1;
        end
        StDecide: begin
          trise_q <= up || down ? 8'd0 : tr;
          tfall_q <= up || down ? 8'd0 : tf;
          lrise_q <= up ? {1'b0, lr[7:1]} : (down ? 8'd0 : lr);
          lfall_q <= up || down ? 8'd0 : lf;
          ov_q <= 1'b1;
        end
        StOut: begin
          run_max_q <= 7'd0;
          run_min_q <= LoadFull;
        end
        default: ;
      endcase
    end
  end

  // divider datapath and payload registers, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          tasks_q <= running_tasks_i;
          n_q <= n_in;
          rem_q <= 33'd0;
          quot_q <= 39'd0;
          if (!skip) begin
            // 100*(dwall-didle) in 39 bits, divided by dwall
            dividend_q <= 39'(dwall - didle) * 39'd100;
            divisor_q <= dwall;
          end else begin
            dividend_q <= {17'(running_tasks_i) * 17'd100, 22'd0};
            divisor_q <= {28'd0, n_in};
          end
        end
      end
      StLoadDiv, StAvgDiv: begin
        if (state_q == StLoadDiv && cnt_q == 6'd0) begin
          // reload for the task average
          rem_q <= 33'd0;
          quot_q <= 39'd0;
          dividend_q <= {17'(tasks_q) * 17'd100, 22'd0};
          divisor_q <= {28'd0, n_q};
        end else begin
          dividend_q <= {dividend_q[37:0], 1'b0};
          if (!trial[32]) begin
            rem_q <= trial;
            quot_q <= {quot_q[37:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quot_q <= {quot_q[37:0], 1'b0};
          end
        end
      end
      StDecide: begin
        act_q <= up ? ActUp : (down ? ActDown : ActNone);
        tgt_q <= up ? n_q : (down ? n_q - 4'd1 : 4'd0);
        omax_q <= run_max_q;
        omin_q <= run_min_q;
        oavg_q <= avg;
      end
      default: ;
    endcase
  end

endmodule
